### rtl/tpbc_pkg.sv
package tpbc_pkg;

  localparam int unsigned PtrW = 64;
  localparam int unsigned LenW = 48;
  localparam int unsigned InDataW = 176;
  localparam int unsigned OutDataW = 216;

  typedef enum logic [2:0] {
    MODE_PROTECT = 3'd0,
    MODE_CHECK   = 3'd1,
    MODE_FREE    = 3'd2,
    MODE_RETAG   = 3'd3,
    MODE_QUERY   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNTRACKED = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_INVALID   = 3'd3,
    ST_OOB       = 3'd4,
    ST_STALE     = 3'd5,
    ST_INTERIOR  = 3'd6,
    ST_NULL      = 3'd7
  } status_e;

  typedef struct packed {
    logic clr_step;
    logic rd_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } sts_t;

endpackage

### rtl/tagged_pointer_bounds_checker.sv
// an accepted word has its table entry read, then its table write-back done and its
// result registered on the master side; a new word is taken only after that write-back
// a result waiting on the master side holds back only the write-back of the next word
// reset: the table is swept one entry a cycle, all NUM_TAGS entries, before the first
// word is taken; the free list is rebuilt as 1 to NUM_TAGS-1
module tagged_pointer_bounds_checker #(
  parameter int unsigned NUM_TAGS  = 4096,
  parameter int unsigned TAG_SHIFT = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [175:0] s_axis_tdata,  // pointer_in, length_in, old_pointer
  input  logic [2:0]   s_axis_tuser,  // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pointer_out, object_size, object_base, violation_underflow, violation_bytes, zero pad
  output logic [215:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser   // status
);

  tpbc_pkg::cmd_t cmd;
  tpbc_pkg::sts_t sts;

  tpbc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  tpbc_datapath #(
    .NUM_TAGS  (NUM_TAGS),
    .TAG_SHIFT (TAG_SHIFT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_data_i    (s_axis_tdata),
    .in_mode_i    (s_axis_tuser),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

endmodule

### rtl/tpbc_ctrl.sv
module tpbc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  input  tpbc_pkg::sts_t sts_i,
  output tpbc_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    s_axis_tready  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_q || m_axis_tready) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;

endmodule

### rtl/tpbc_datapath.sv
module tpbc_datapath #(
  parameter int unsigned NUM_TAGS  = 4096,
  parameter int unsigned TAG_SHIFT = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tpbc_pkg::cmd_t                   cmd_i,
  output tpbc_pkg::sts_t                   sts_o,
  input  logic [tpbc_pkg::InDataW-1:0]     in_data_i,
  input  logic [2:0]                       in_mode_i,
  output logic [tpbc_pkg::OutDataW-1:0]    out_data_o,
  output logic [2:0]                       out_status_o
);

  localparam int unsigned LW = $clog2(NUM_TAGS);
  localparam int unsigned TW = 64 - TAG_SHIFT;
  localparam int unsigned AW = TAG_SHIFT;
  localparam int unsigned SW = ((AW > 48) ? AW : 48) + 1;

  // object table
  logic [AW-1:0] base_mem [NUM_TAGS];
  logic [47:0]   size_mem [NUM_TAGS];
  logic [LW-1:0] link_mem [NUM_TAGS];

  tpbc_pkg::mode_e mode_q;
  logic [63:0]     ptr_q, old_q;
  logic [47:0]     len_q;
  logic [SW-1:0]   aend_q;
  logic [AW-1:0]   base_rd_q;
  logic [47:0]     size_rd_q;
  logic [LW-1:0]   link_rd_q;
  logic [LW-1:0]   free_head_q, free_head_d;
  logic [LW-1:0]   clr_cnt_q;

  logic [63:0]     out_ptr_q, out_ptr_d;
  logic [47:0]     out_size_q, out_size_d;
  logic [47:0]     out_base_q, out_base_d;
  logic            out_under_q, out_under_d;
  logic [47:0]     out_bytes_q, out_bytes_d;
  tpbc_pkg::status_e out_st_q, out_st_d;

  logic [63:0]   in_ptr, in_old;
  logic [47:0]   in_len;
  logic [TW-1:0] in_tag;
  logic [LW-1:0] rd_addr;

  logic [TW-1:0] tag, otag, sel_tag;
  logic [AW-1:0] addr, eb;
  logic [47:0]   es;
  logic          sel_range;
  logic [SW-1:0] oend;
  logic [63:0]   addr_mask;

  logic          we, link_we;
  logic [LW-1:0] waddr;
  logic [AW-1:0] wbase;
  logic [47:0]   wsize;
  logic [LW-1:0] wlink;

  assign in_ptr  = in_data_i[63:0];
  assign in_len  = in_data_i[111:64];
  assign in_old  = in_data_i[175:112];
  assign in_tag  = (in_mode_i == tpbc_pkg::MODE_RETAG) ? in_old[63:TAG_SHIFT]
                                                        : in_ptr[63:TAG_SHIFT];
  assign rd_addr = LW'(in_tag);

  assign sts_o.clr_last = (clr_cnt_q == LW'(NUM_TAGS - 1));

  assign tag       = ptr_q[63:TAG_SHIFT];
  assign otag      = old_q[63:TAG_SHIFT];
  assign addr      = ptr_q[AW-1:0];
  assign sel_tag   = (mode_q == tpbc_pkg::MODE_RETAG) ? otag : tag;
  assign sel_range = (sel_tag != '0) && (33'(sel_tag) < 33'(NUM_TAGS));
  assign eb        = sel_range ? base_rd_q : '0;
  assign es        = sel_range ? size_rd_q : '0;
  assign oend      = SW'(eb) + SW'(es);
  assign addr_mask = (64'd1 << TAG_SHIFT) - 64'd1;

  always_comb begin
    out_st_d    = tpbc_pkg::ST_UNTRACKED;
    out_ptr_d   = '0;
    out_size_d  = '0;
    out_base_d  = '0;
    out_under_d = 1'b0;
    out_bytes_d = '0;
    free_head_d = free_head_q;
    we          = 1'b0;
    link_we     = 1'b0;
    waddr       = free_head_q;
    wbase       = '0;
    wsize       = '0;
    wlink       = free_head_q;
    case (mode_q)
      tpbc_pkg::MODE_PROTECT: begin
        if (addr == '0) begin
          out_st_d = tpbc_pkg::ST_NULL;
        end else if (free_head_q == '0) begin
          out_st_d  = tpbc_pkg::ST_EXHAUSTED;
          out_ptr_d = ptr_q;
        end else begin
          out_st_d    = tpbc_pkg::ST_OK;
          out_ptr_d   = (64'(free_head_q) << TAG_SHIFT) | 64'(addr);
          out_size_d  = len_q;
          out_base_d  = 48'(addr);
          free_head_d = link_rd_q;
          we          = 1'b1;
          wbase       = addr;
          wsize       = len_q;
        end
      end
      tpbc_pkg::MODE_CHECK: begin
        if (ptr_q[63] || tag == '0) begin
          out_st_d = tpbc_pkg::ST_UNTRACKED;
        end else begin
          out_size_d = es;
          out_base_d = 48'(eb);
          if (!sel_range || eb == '0) begin
            out_st_d = tpbc_pkg::ST_INVALID;
          end else if (addr < eb) begin
            out_st_d    = tpbc_pkg::ST_OOB;
            out_under_d = 1'b1;
            out_bytes_d = 48'(eb - addr);
          end else if (aend_q > oend) begin
            out_st_d    = tpbc_pkg::ST_OOB;
            out_bytes_d = 48'(aend_q - oend);
          end else begin
            out_st_d = tpbc_pkg::ST_OK;
          end
        end
      end
      tpbc_pkg::MODE_FREE: begin
        if (tag == '0) begin
          out_st_d  = tpbc_pkg::ST_UNTRACKED;
          out_ptr_d = ptr_q;
        end else if (!sel_range) begin
          out_st_d = tpbc_pkg::ST_INVALID;
        end else begin
          out_size_d = es;
          out_base_d = 48'(eb);
          if (eb == '0) begin
            out_st_d = tpbc_pkg::ST_STALE;
          end else if (addr != eb) begin
            out_st_d = tpbc_pkg::ST_INTERIOR;
          end else begin
            out_st_d    = tpbc_pkg::ST_OK;
            out_ptr_d   = 64'(eb);
            free_head_d = LW'(tag);
            we          = 1'b1;
            link_we     = 1'b1;
            waddr       = LW'(tag);
          end
        end
      end
      tpbc_pkg::MODE_RETAG: begin
        out_size_d = es;
        out_base_d = 48'(eb);
        if (ptr_q == '0) begin
          out_st_d = tpbc_pkg::ST_NULL;
        end else if (old_q[63] || otag == '0) begin
          out_st_d  = tpbc_pkg::ST_UNTRACKED;
          out_ptr_d = ptr_q;
        end else if (!sel_range || eb == '0) begin
          out_st_d  = tpbc_pkg::ST_INVALID;
          out_ptr_d = ptr_q;
        end else begin
          out_st_d  = tpbc_pkg::ST_OK;
          out_ptr_d = (ptr_q & addr_mask) | (old_q & ~addr_mask);
        end
      end
      tpbc_pkg::MODE_QUERY: begin
        if (tag == '0) begin
          out_st_d = tpbc_pkg::ST_UNTRACKED;
        end else begin
          out_size_d = es;
          out_base_d = 48'(eb);
          if (!sel_range || eb == '0) begin
            out_st_d = tpbc_pkg::ST_INVALID;
          end else begin
            out_st_d = tpbc_pkg::ST_OK;
          end
        end
      end
      default: begin
        out_st_d = tpbc_pkg::ST_UNTRACKED;
      end
    endcase
    we      = we & cmd_i.commit;
    link_we = link_we & cmd_i.commit;
    if (!cmd_i.commit) begin
      free_head_d = free_head_q;
    end
    if (cmd_i.clr_step) begin
      we      = 1'b1;
      link_we = 1'b1;
      waddr   = clr_cnt_q;
      wbase   = '0;
      wsize   = '0;
      wlink   = sts_o.clr_last ? '0 : clr_cnt_q + LW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      base_mem[waddr] <= wbase;
      size_mem[waddr] <= wsize;
    end
    if (link_we) begin
      link_mem[waddr] <= wlink;
    end
    if (cmd_i.rd_en) begin
      base_rd_q <= base_mem[rd_addr];
      size_rd_q <= size_mem[rd_addr];
      link_rd_q <= link_mem[free_head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      mode_q <= tpbc_pkg::mode_e'(in_mode_i);
      ptr_q  <= in_ptr;
      len_q  <= in_len;
      old_q  <= in_old;
      aend_q <= SW'(in_ptr[AW-1:0]) + SW'(in_len);
    end
    if (cmd_i.commit) begin
      out_st_q    <= out_st_d;
      out_ptr_q   <= out_ptr_d;
      out_size_q  <= out_size_d;
      out_base_q  <= out_base_d;
      out_under_q <= out_under_d;
      out_bytes_q <= out_bytes_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= LW'(1);
      clr_cnt_q   <= '0;
    end else begin
      free_head_q <= free_head_d;
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + LW'(1);
      end
    end
  end

  assign out_status_o = out_st_q;
  assign out_data_o   = {7'd0, out_bytes_q, out_under_q, out_base_q, out_size_q, out_ptr_q};

endmodule

### tb/tagged_pointer_bounds_checker_tb.sv
module tagged_pointer_bounds_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumTags       = 4096;
  localparam int unsigned TagShift      = 48;
  localparam int unsigned RandomWords   = 250;
  localparam int unsigned FillWords     = 225;
  localparam int unsigned WatchdogLimit = 20000;

  typedef struct {
    logic [2:0]  mode;
    logic [63:0] ptr;
    logic [47:0] len;
    logic [63:0] old_ptr;
    bit          on_live;  // aim the pointer (old pointer for retag) at a live object
    logic [47:0] delta;    // address offset from the live object's base
  } tbl_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] ptr;
    logic [47:0] size;
    logic [47:0] base;
    logic        under;
    logic [47:0] bytes;
  } tbl_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata = '0;  // pointer_in, length_in, old_pointer
  logic [2:0]   s_axis_tuser = '0;  // mode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // pointer_out, object_size, object_base, violation_underflow, violation_bytes, zero pad
  logic [215:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;       // status

  tagged_pointer_bounds_checker #(
    .NUM_TAGS (NumTags),
    .TAG_SHIFT(TagShift)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // shadow object table
  logic [47:0] obj_base [NumTags];
  logic [47:0] obj_size [NumTags];
  int unsigned obj_link [NumTags];
  int unsigned free_head;
  int unsigned live_tags [$];

  tbl_req_t    pending_words [$];
  tbl_result_t results_due [$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mode_count [8];
  int unsigned status_count [8];
  bit          in_fire = 1'b0;
  tbl_req_t    drv_req;

  initial begin
    for (int i = 0; i < NumTags; i++) begin
      obj_base[i] = '0;
      obj_size[i] = '0;
      obj_link[i] = i + 1;
    end
    obj_link[NumTags-1] = 0;
    free_head = 1;
    for (int i = 0; i < 8; i++) begin
      mode_count[i] = 0;
      status_count[i] = 0;
    end
  end

  function automatic void drop_live(int unsigned tag);
    for (int i = 0; i < live_tags.size(); i++) begin
      if (live_tags[i] == tag) begin
        live_tags.delete(i);
        break;
      end
    end
  endfunction

  function automatic tbl_result_t predict_table_op(logic [2:0] mode, logic [63:0] ptr,
                                                   logic [47:0] len, logic [63:0] old_ptr);
    tbl_result_t r;
    logic [15:0] tag, otag;
    logic [47:0] addr, eb, es, ob, os;
    logic [48:0] a_end, o_end;
    bit          in_rng, o_rng;
    int unsigned t;
    r = '0;
    tag = ptr[63:TagShift];
    addr = ptr[TagShift-1:0];
    in_rng = (tag != 0) && (tag < NumTags);
    eb = '0;
    es = '0;
    if (in_rng) begin
      eb = obj_base[tag];
      es = obj_size[tag];
    end
    case (mode)
      tpbc_pkg::MODE_PROTECT: begin
        t = free_head;
        if (addr == '0) begin
          r.status = tpbc_pkg::ST_NULL;
        end else if (t == 0 || t >= NumTags || obj_link[t] >= NumTags) begin
          r.status = tpbc_pkg::ST_EXHAUSTED;
          r.ptr = ptr;
        end else begin
          free_head = obj_link[t];
          obj_base[t] = addr;
          obj_size[t] = len;
          live_tags.push_back(t);
          r.status = tpbc_pkg::ST_OK;
          r.ptr = {16'(t), addr};
          r.size = len;
          r.base = addr;
        end
      end
      tpbc_pkg::MODE_CHECK: begin
        if (ptr[63] || tag == 0) begin
          r.status = tpbc_pkg::ST_UNTRACKED;
        end else begin
          r.size = es;
          r.base = eb;
          a_end = {1'b0, addr} + {1'b0, len};
          o_end = {1'b0, eb} + {1'b0, es};
          if (!in_rng || eb == '0) begin
            r.status = tpbc_pkg::ST_INVALID;
          end else if (addr < eb) begin
            r.status = tpbc_pkg::ST_OOB;
            r.under = 1'b1;
            r.bytes = eb - addr;
          end else if (a_end > o_end) begin
            r.status = tpbc_pkg::ST_OOB;
            r.bytes = 48'(a_end - o_end);
          end else begin
            r.status = tpbc_pkg::ST_OK;
          end
        end
      end
      tpbc_pkg::MODE_FREE: begin
        if (tag == 0) begin
          r.status = tpbc_pkg::ST_UNTRACKED;
          r.ptr = ptr;
        end else if (!in_rng) begin
          r.status = tpbc_pkg::ST_INVALID;
        end else begin
          r.size = es;
          r.base = eb;
          if (eb == '0) begin
            r.status = tpbc_pkg::ST_STALE;
          end else if (addr != eb) begin
            r.status = tpbc_pkg::ST_INTERIOR;
          end else begin
            obj_base[tag] = '0;
            obj_size[tag] = '0;
            obj_link[tag] = free_head;
            free_head = tag;
            drop_live(tag);
            r.status = tpbc_pkg::ST_OK;
            r.ptr = {16'b0, eb};
          end
        end
      end
      tpbc_pkg::MODE_RETAG: begin
        otag = old_ptr[63:TagShift];
        o_rng = (otag != 0) && (otag < NumTags);
        ob = '0;
        os = '0;
        if (o_rng) begin
          ob = obj_base[otag];
          os = obj_size[otag];
        end
        r.size = os;
        r.base = ob;
        if (ptr == '0) begin
          r.status = tpbc_pkg::ST_NULL;
        end else if (old_ptr[63] || otag == 0) begin
          r.status = tpbc_pkg::ST_UNTRACKED;
          r.ptr = ptr;
        end else if (!o_rng || ob == '0) begin
          r.status = tpbc_pkg::ST_INVALID;
          r.ptr = ptr;
        end else begin
          r.status = tpbc_pkg::ST_OK;
          r.ptr = {otag, addr};
        end
      end
      tpbc_pkg::MODE_QUERY: begin
        if (tag == 0) begin
          r.status = tpbc_pkg::ST_UNTRACKED;
        end else begin
          r.size = es;
          r.base = eb;
          r.status = (!in_rng || eb == '0) ? tpbc_pkg::ST_INVALID : tpbc_pkg::ST_OK;
        end
      end
      default: r.status = tpbc_pkg::ST_UNTRACKED;
    endcase
    return r;
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [63:0] rand_ptr();
    logic [15:0] tag;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 15) tag = '0;
    else if (sel < 55) tag = 16'($urandom_range(NumTags - 1, 1));
    else if (sel < 75) tag = 16'($urandom_range(16'h7fff, NumTags));
    else tag = 16'h8000 | 16'($urandom);
    return {tag, rand48()};
  endfunction

  function automatic logic [47:0] rand_len();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60) return 48'($urandom_range(64));
    if (sel < 80) return 48'($urandom_range(1024));
    if (sel < 90) return rand48();
    if (sel < 95) return '0;
    return '1;
  endfunction

  function automatic tbl_req_t raw_req(logic [2:0] mode, logic [63:0] ptr,
                                       logic [47:0] len, logic [63:0] old_ptr);
    tbl_req_t r;
    r.mode = mode;
    r.ptr = ptr;
    r.len = len;
    r.old_ptr = old_ptr;
    r.on_live = 1'b0;
    r.delta = '0;
    return r;
  endfunction

  function automatic tbl_req_t protect_req();
    tbl_req_t r;
    r = raw_req(tpbc_pkg::MODE_PROTECT, {16'($urandom), rand48()}, rand_len(),
                {$urandom, $urandom});
    if (r.ptr[47:0] == '0) r.ptr[0] = 1'b1;
    return r;
  endfunction

  function automatic tbl_req_t random_req();
    tbl_req_t    r;
    int unsigned sel;
    sel = $urandom_range(99);
    r = raw_req(tpbc_pkg::MODE_QUERY, rand_ptr(), rand_len(), {$urandom, $urandom});
    if (sel < 30) begin
      r = protect_req();
      if ($urandom_range(49) == 0) r.ptr[47:0] = '0;
    end else if (sel < 55) begin
      r.mode = tpbc_pkg::MODE_CHECK;
      r.on_live = $urandom_range(9) < 8;
      case ($urandom_range(4))
        0: r.delta = 48'(0) - 48'($urandom_range(32, 1));
        1: r.delta = rand48();
        default: r.delta = 48'($urandom_range(64));
      endcase
    end else if (sel < 70) begin
      r.mode = tpbc_pkg::MODE_FREE;
      r.on_live = $urandom_range(9) < 8;
      r.delta = ($urandom_range(9) < 8) ? '0 : 48'($urandom_range(8, 1));
    end else if (sel < 80) begin
      r.mode = tpbc_pkg::MODE_RETAG;
      r.on_live = $urandom_range(3) < 3;
      r.old_ptr = rand_ptr();
      if ($urandom_range(19) == 0) r.ptr = '0;
    end else if (sel < 97) begin
      r.on_live = $urandom_range(9) < 7;
    end else begin
      r.mode = 3'($urandom_range(7, 5));
    end
    return r;
  endfunction

  // bind a live object to the word just before it goes on the bus
  function automatic tbl_req_t aim_at_live(tbl_req_t r);
    int unsigned t;
    if (r.on_live && live_tags.size() > 0) begin
      t = live_tags[$urandom_range(live_tags.size() - 1)];
      if (r.mode == tpbc_pkg::MODE_RETAG) r.old_ptr = {16'(t), r.old_ptr[47:0]};
      else r.ptr = {16'(t), obj_base[t] + r.delta};
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0 || s_axis_tvalid || results_due.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // sender side
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          drv_req = aim_at_live(pending_words.pop_front());
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {drv_req.old_ptr, drv_req.len, drv_req.ptr};
          s_axis_tuser <= drv_req.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= $urandom_range(99) >= snk_idle_pct;
    end
  end

  // accepted words on both sides
  always @(posedge clk_i) begin
    tbl_result_t exp_res;
    bit          out_fire;
    out_fire = m_axis_tvalid && m_axis_tready;
    in_fire <= s_axis_tvalid && s_axis_tready;
    quiet_cycles <= (out_fire || (s_axis_tvalid && s_axis_tready)) ? 0 : quiet_cycles + 1;
    if (out_fire) begin
      status_count[m_axis_tuser]++;
      if (results_due.size() == 0) begin
        $error("result word with status %0d arrived with nothing outstanding", m_axis_tuser);
        mismatches++;
      end else begin
        exp_res = results_due.pop_front();
        compare_field("status", 64'(exp_res.status), 64'(m_axis_tuser));
        compare_field("pointer_out", exp_res.ptr, m_axis_tdata[63:0]);
        compare_field("object_size", 64'(exp_res.size), 64'(m_axis_tdata[111:64]));
        compare_field("object_base", 64'(exp_res.base), 64'(m_axis_tdata[159:112]));
        compare_field("violation_underflow", 64'(exp_res.under), 64'(m_axis_tdata[160]));
        compare_field("violation_bytes", 64'(exp_res.bytes), 64'(m_axis_tdata[208:161]));
        compare_field("pad", 64'h0, 64'(m_axis_tdata[215:209]));
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      mode_count[s_axis_tuser]++;
      results_due.push_back(predict_table_op(s_axis_tuser, s_axis_tdata[63:0],
                                             s_axis_tdata[111:64], s_axis_tdata[175:112]));
    end
  end

  initial begin
    while (quiet_cycles < WatchdogLimit) @(posedge clk_i);
    $display("watchdog: no word moved for %0d cycles", WatchdogLimit);
    $display("tagged_pointer_bounds_checker regression: fail");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 24;
    snk_idle_pct = 73;
    // after reset the free list hands out tags 1 then 2
    pending_words.push_back(raw_req(tpbc_pkg::MODE_PROTECT, 64'hffff_0000_0000_0000, 48'd5, '0));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_PROTECT, 64'h0000_ffff_ffff_ffff, '1, '1));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_PROTECT, 64'h1234_0000_0000_0001, 48'd16, '0));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_CHECK, 64'h0002_0000_0000_0001, 48'd16, '0));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_CHECK, 64'h0002_0000_0000_0000, 48'd4, '0));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_CHECK, 64'h0002_0000_0000_0001, 48'd17, '0));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_CHECK, 64'h0001_ffff_ffff_ffff, '1, '0));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_CHECK, 64'h8002_0000_0000_0001, 48'd1, '0));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_CHECK, 64'h0000_0000_0000_0001, 48'd1, '0));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_CHECK, 64'h0fff_0000_0000_0010, 48'd1, '0));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_CHECK, 64'h7fff_0000_0000_0010, 48'd1, '0));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_QUERY, 64'h0001_0000_0000_0000, '0, '0));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_QUERY, 64'h0000_ffff_ffff_ffff, '0, '0));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_QUERY, 64'h1388_0000_0000_0000, '0, '0));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_RETAG, '0, '0, 64'h0002_0000_0000_0001));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_RETAG, 64'h5, '0, 64'h8002_0000_0000_0001));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_RETAG, 64'h5, '0, 64'h0000_0000_0000_0001));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_RETAG, 64'h5, '0, 64'h0bb8_0000_0000_0001));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_RETAG, 64'h5, '0, 64'h7fff_0000_0000_0001));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_RETAG, '1, '0, 64'h0002_0000_0000_0007));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_FREE, 64'h0000_0000_0000_1234, '0, '0));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_FREE, 64'h9000_0000_0000_0001, '0, '0));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_FREE, 64'h0007_0000_0000_0001, '0, '0));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_FREE, 64'h0002_0000_0000_0002, '0, '0));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_FREE, 64'h0002_0000_0000_0001, '0, '0));
    pending_words.push_back(raw_req(tpbc_pkg::MODE_FREE, 64'h0002_0000_0000_0001, '0, '0));
    for (int m = 5; m < 8; m++) pending_words.push_back(raw_req(3'(m), '1, '1, '1));
    repeat (RandomWords) pending_words.push_back(random_req());
    wait_drained();

    src_idle_pct = 73;
    snk_idle_pct = 24;
    // fill part of the table, then hand tags back in random order
    repeat (FillWords) pending_words.push_back(protect_req());
    repeat (FillWords) begin
      pending_words.push_back(raw_req(tpbc_pkg::MODE_FREE, rand_ptr(), rand_len(),
                                      {$urandom, $urandom}));
      pending_words[$].on_live = 1'b1;
    end
    repeat (RandomWords) pending_words.push_back(random_req());
    wait_drained();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    repeat (RandomWords) pending_words.push_back(random_req());
    wait_drained();
    repeat (16) @(posedge clk_i);

    $display("words in: protect %0d, check %0d, free %0d, retag %0d, query %0d, unknown %0d",
             mode_count[tpbc_pkg::MODE_PROTECT], mode_count[tpbc_pkg::MODE_CHECK],
             mode_count[tpbc_pkg::MODE_FREE], mode_count[tpbc_pkg::MODE_RETAG],
             mode_count[tpbc_pkg::MODE_QUERY],
             mode_count[5] + mode_count[6] + mode_count[7]);
    $display({"results: ok %0d, untracked %0d, exhausted %0d, invalid %0d, ",
              "out of bounds %0d, stale %0d, interior %0d, null %0d"},
             status_count[tpbc_pkg::ST_OK], status_count[tpbc_pkg::ST_UNTRACKED],
             status_count[tpbc_pkg::ST_EXHAUSTED], status_count[tpbc_pkg::ST_INVALID],
             status_count[tpbc_pkg::ST_OOB], status_count[tpbc_pkg::ST_STALE],
             status_count[tpbc_pkg::ST_INTERIOR], status_count[tpbc_pkg::ST_NULL]);
    if (mismatches == 0) begin
      $display("tagged_pointer_bounds_checker regression: pass");
    end else begin
      $display("tagged_pointer_bounds_checker regression: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/tpbc_pkg.sv
rtl/tpbc_ctrl.sv
rtl/tpbc_datapath.sv
rtl/tagged_pointer_bounds_checker.sv
tb/tagged_pointer_bounds_checker_tb.sv
